// ===== rtl/core/urff_pkg.sv =====
// Shared types, constants and helpers for the unsigned radix field formatter.
// No dependencies; all other files but urff_out_if use it by scoped names.
package urff_pkg;

	localparam int MAX_FIELD    = 64;
	localparam int VALUE_W      = 32;
	localparam int FIELD_W      = 7;
	localparam int DIGIT_W      = 4;
	localparam int DEC_DIGITS   = 10;
	localparam int HEX_DIGITS   = VALUE_W / DIGIT_W;
	localparam int DIG_BITS     = DEC_DIGITS * DIGIT_W;
	localparam int NDIG_W       = 4;
	localparam int STEP_W       = 5;
	localparam int DABBLE_STEPS = VALUE_W;

	localparam logic [1:0] ACT_DEC   = 2'd0;
	localparam logic [1:0] ACT_LOWER = 2'd1;
	localparam logic [1:0] ACT_UPPER = 2'd2;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_NONE  = 8'h00;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_DABBLE,
		CV_NORM
	} cv_state_t;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_CONV,
		TS_EMIT
	} top_state_t;

	// Layout of one field, handed from the top level to the emitter.
	typedef struct packed {
		logic [FIELD_W-1:0] pad;
		logic [FIELD_W-1:0] zeros;
		logic [NDIG_W-1:0]  ndig;
		logic               left;
		logic               pad_zero;
		logic               upper;
	} plan_t;

	function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
		logic [7:0] d8;
		d8 = {4'b0, d};
		if (d < 4'd10)
			return CHAR_ZERO + d8;
		else
			return (upper ? CHAR_UA : CHAR_LA) + d8 - 8'd10;
	endfunction

endpackage

// ===== rtl/core/urff_in_if.sv =====
// Input channel of the formatter: valid/ready plus the fields of one item.
// Uses widths from urff_pkg.
interface urff_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [urff_pkg::VALUE_W-1:0]  value;
	logic [urff_pkg::FIELD_W-1:0]  field_width;
	logic [urff_pkg::FIELD_W-1:0]  precision;
	logic                          has_precision;
	logic                          left_justify;
	logic                          zero_pad;

	modport source (
		output valid, action, value, field_width, precision,
		       has_precision, left_justify, zero_pad,
		input  ready
	);
	modport sink (
		input  valid, action, value, field_width, precision,
		       has_precision, left_justify, zero_pad,
		output ready
	);
endinterface

// ===== rtl/core/urff_out_if.sv =====
// Output channel of the formatter: valid/ready plus one character item.
// No dependencies.
interface urff_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       char_valid;
	logic       last_char;

	modport source (output valid, char_code, char_valid, last_char, input ready);
	modport sink   (input  valid, char_code, char_valid, last_char, output ready);
endinterface

// ===== rtl/core/urff_conv.sv =====
// Digit converter: bit-serial double dabble for decimal, direct nibble load for hex,
// then a leading-zero strip one digit per cycle. Depends on urff_pkg.
module urff_conv (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                decimal,
	input  logic [urff_pkg::VALUE_W-1:0]        value,
	input  logic                                pop,
	output logic                                done,
	output logic [urff_pkg::NDIG_W-1:0]         ndig,
	output logic [urff_pkg::DIGIT_W-1:0]        top_digit
);

	urff_pkg::cv_state_t state_q, state_d;

	logic [urff_pkg::VALUE_W-1:0]  bin_q;
	logic [urff_pkg::DIG_BITS-1:0] dig_q;
	logic [urff_pkg::DIG_BITS-1:0] dig_adj;
	logic [urff_pkg::NDIG_W-1:0]   ndig_q;
	logic [urff_pkg::STEP_W-1:0]   step_q;
	logic                          strip;

	assign top_digit = dig_q[urff_pkg::DIG_BITS-1 -: urff_pkg::DIGIT_W];
	assign ndig      = ndig_q;
	assign strip     = (ndig_q > urff_pkg::NDIG_W'(1)) && (top_digit == '0);

	// add 3 to every BCD digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < urff_pkg::DEC_DIGITS; i++) begin
			if (dig_q[i*urff_pkg::DIGIT_W +: urff_pkg::DIGIT_W] >= 4'd5)
				dig_adj[i*urff_pkg::DIGIT_W +: urff_pkg::DIGIT_W] =
					dig_q[i*urff_pkg::DIGIT_W +: urff_pkg::DIGIT_W] + 4'd3;
			else
				dig_adj[i*urff_pkg::DIGIT_W +: urff_pkg::DIGIT_W] =
					dig_q[i*urff_pkg::DIGIT_W +: urff_pkg::DIGIT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= urff_pkg::CV_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			urff_pkg::CV_IDLE: begin
				if (start)
					state_d = decimal ? urff_pkg::CV_DABBLE : urff_pkg::CV_NORM;
			end
			urff_pkg::CV_DABBLE: begin
				if (step_q == urff_pkg::STEP_W'(urff_pkg::DABBLE_STEPS - 1))
					state_d = urff_pkg::CV_NORM;
			end
			urff_pkg::CV_NORM: begin
				if (!strip) begin
					done    = 1'b1;
					state_d = urff_pkg::CV_IDLE;
				end
			end
			default: state_d = urff_pkg::CV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			ndig_q <= '0;
		end else begin
			case (state_q)
				urff_pkg::CV_IDLE: begin
					if (start) begin
						step_q <= '0;
						ndig_q <= decimal ? urff_pkg::NDIG_W'(urff_pkg::DEC_DIGITS)
						                  : urff_pkg::NDIG_W'(urff_pkg::HEX_DIGITS);
					end else if (pop) begin
						ndig_q <= ndig_q - urff_pkg::NDIG_W'(1);
					end
				end
				urff_pkg::CV_DABBLE: step_q <= step_q + urff_pkg::STEP_W'(1);
				urff_pkg::CV_NORM: begin
					if (strip)
						ndig_q <= ndig_q - urff_pkg::NDIG_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			urff_pkg::CV_IDLE: begin
				if (start) begin
					bin_q <= value;
					if (decimal)
						dig_q <= '0;
					else
						dig_q <= {value, {(urff_pkg::DIG_BITS-urff_pkg::VALUE_W){1'b0}}};
				end else if (pop) begin
					dig_q <= {dig_q[urff_pkg::DIG_BITS-urff_pkg::DIGIT_W-1:0],
					          {urff_pkg::DIGIT_W{1'b0}}};
				end
			end
			urff_pkg::CV_DABBLE: begin
				dig_q <= {dig_adj[urff_pkg::DIG_BITS-2:0], bin_q[urff_pkg::VALUE_W-1]};
				bin_q <= {bin_q[urff_pkg::VALUE_W-2:0], 1'b0};
			end
			urff_pkg::CV_NORM: begin
				if (strip)
					dig_q <= {dig_q[urff_pkg::DIG_BITS-urff_pkg::DIGIT_W-1:0],
					          {urff_pkg::DIGIT_W{1'b0}}};
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/urff_emit.sv =====
// Character emitter: walks the field one character per unstalled cycle into an output
// register, popping digits from the converter. Depends on urff_pkg and urff_out_if.
module urff_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  urff_pkg::plan_t                plan,
	input  logic [urff_pkg::DIGIT_W-1:0]   top_digit,
	output logic                           pop,
	output logic                           done,
	urff_out_if.source                     out_item
);

	logic                          busy_q;
	logic                          empty_q;
	logic                          pad_zero_q;
	logic                          upper_q;
	logic [urff_pkg::FIELD_W-1:0]  pos_q;
	logic [urff_pkg::FIELD_W-1:0]  lead_q;
	logic [urff_pkg::FIELD_W-1:0]  b1_q;
	logic [urff_pkg::FIELD_W-1:0]  b2_q;
	logic [urff_pkg::FIELD_W-1:0]  tot_q;
	logic [urff_pkg::FIELD_W-1:0]  lead_d;
	logic [urff_pkg::FIELD_W-1:0]  b1_d;
	logic [urff_pkg::FIELD_W-1:0]  ndig7;
	logic                          ov_q;
	logic [7:0]                    char_q;
	logic                          cvalid_q;
	logic                          last_q;
	logic                          fire;
	logic                          last;
	logic [7:0]                    ch;

	assign ndig7  = {{(urff_pkg::FIELD_W-urff_pkg::NDIG_W){1'b0}}, plan.ndig};
	assign lead_d = plan.left ? '0 : plan.pad;
	assign b1_d   = lead_d + plan.zeros;

	assign fire = busy_q && (!ov_q || out_item.ready);
	assign last = empty_q || (pos_q + urff_pkg::FIELD_W'(1) == tot_q);
	assign done = fire && last;
	assign pop  = fire && !empty_q && (pos_q >= b1_q) && (pos_q < b2_q);

	always_comb begin
		if (pos_q < lead_q)
			ch = pad_zero_q ? urff_pkg::CHAR_ZERO : urff_pkg::CHAR_SPACE;
		else if (pos_q < b1_q)
			ch = urff_pkg::CHAR_ZERO;
		else if (pos_q < b2_q)
			ch = urff_pkg::digit_char(top_digit, upper_q);
		else
			ch = urff_pkg::CHAR_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (start)
				busy_q <= 1'b1;
			else if (done)
				busy_q <= 1'b0;
			if (fire)
				ov_q <= 1'b1;
			else if (out_item.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pos_q      <= '0;
			lead_q     <= lead_d;
			b1_q       <= b1_d;
			b2_q       <= b1_d + ndig7;
			tot_q      <= plan.pad + plan.zeros + ndig7;
			empty_q    <= (plan.pad == '0) && (plan.zeros == '0) && (plan.ndig == '0);
			pad_zero_q <= plan.pad_zero;
			upper_q    <= plan.upper;
		end else if (fire) begin
			pos_q <= pos_q + urff_pkg::FIELD_W'(1);
		end
		if (fire) begin
			char_q   <= empty_q ? urff_pkg::CHAR_NONE : ch;
			cvalid_q <= !empty_q;
			last_q   <= last;
		end
	end

	assign out_item.valid      = ov_q;
	assign out_item.char_code  = char_q;
	assign out_item.char_valid = cvalid_q;
	assign out_item.last_char  = last_q;

endmodule

// ===== rtl/core/unsigned_radix_field_formatter.sv =====
// Top level of the unsigned radix field formatter: input capture, field layout and sequencing.
// Depends on urff_pkg, urff_in_if, urff_out_if, urff_conv and urff_emit.
//
//   channel   | dir | payload                                           | item
//   in_item   | in  | action, value, field_width, precision, flags      | one number to format
//   out_item  | out | char_code, char_valid, last_char                 | one character
//
// Steps per item: accept (hex digits load at the accept edge), then the double-dabble
// steps for decimal, the leading-zero strip steps, a layout step, then one character per
// cycle while the output is not stalled, max(field length, 1) characters in all.
// The bit-serial BCD converter and the character emitter set the time per item.
// Reset clears the sequencer, converter and emitter control; payload registers hold junk.
// A stalled output holds the character register; the next item is taken once the last
// character of the current field is in the output register.
module unsigned_radix_field_formatter (
	input  logic      clk,
	input  logic      arst_n,
	urff_in_if.sink   in_item,
	urff_out_if.source out_item
);

	urff_pkg::top_state_t state_q, state_d;

	logic                          upper_q;
	logic                          val_zero_q;
	logic [urff_pkg::FIELD_W-1:0]  width_q;
	logic [urff_pkg::FIELD_W-1:0]  prec_q;
	logic                          dot_q;
	logic                          left_q;
	logic                          zpad_q;

	logic                          accept;
	logic                          conv_done;
	logic                          emit_done;
	logic                          emit_start;
	logic                          pop;
	logic [urff_pkg::NDIG_W-1:0]   conv_ndig;
	logic [urff_pkg::DIGIT_W-1:0]  top_digit;

	logic                          suppress;
	logic [urff_pkg::NDIG_W-1:0]   nd_eff;
	logic [urff_pkg::FIELD_W-1:0]  nd7;
	logic [urff_pkg::FIELD_W-1:0]  len;
	urff_pkg::plan_t               plan;

	assign in_item.ready = (state_q == urff_pkg::TS_IDLE);
	assign accept        = in_item.valid && in_item.ready;

	// capture the item; clamp width and precision to the field limit
	always_ff @(posedge clk) begin
		if (accept) begin
			upper_q    <= (in_item.action != urff_pkg::ACT_LOWER);
			val_zero_q <= (in_item.value == '0);
			width_q    <= (in_item.field_width > urff_pkg::FIELD_W'(urff_pkg::MAX_FIELD))
			              ? urff_pkg::FIELD_W'(urff_pkg::MAX_FIELD) : in_item.field_width;
			prec_q     <= (in_item.precision > urff_pkg::FIELD_W'(urff_pkg::MAX_FIELD))
			              ? urff_pkg::FIELD_W'(urff_pkg::MAX_FIELD) : in_item.precision;
			dot_q      <= in_item.has_precision;
			left_q     <= in_item.left_justify;
			zpad_q     <= in_item.zero_pad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= urff_pkg::TS_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		emit_start = 1'b0;
		case (state_q)
			urff_pkg::TS_IDLE: begin
				if (accept)
					state_d = urff_pkg::TS_CONV;
			end
			urff_pkg::TS_CONV: begin
				if (conv_done) begin
					emit_start = 1'b1;
					state_d    = urff_pkg::TS_EMIT;
				end
			end
			urff_pkg::TS_EMIT: begin
				if (emit_done)
					state_d = urff_pkg::TS_IDLE;
			end
			default: state_d = urff_pkg::TS_IDLE;
		endcase
	end

	// field layout: a zero value with an explicit zero precision prints no digits;
	// precision adds leading zeros, width adds padding
	assign suppress = dot_q && (prec_q == '0) && val_zero_q;
	assign nd_eff   = suppress ? '0 : conv_ndig;
	assign nd7      = {{(urff_pkg::FIELD_W-urff_pkg::NDIG_W){1'b0}}, nd_eff};
	assign len      = (nd_eff == '0) ? '0 : ((prec_q > nd7) ? prec_q : nd7);

	always_comb begin
		plan.ndig     = nd_eff;
		plan.zeros    = len - nd7;
		plan.pad      = (width_q > len) ? (width_q - len) : '0;
		plan.left     = left_q;
		plan.upper    = upper_q;
		plan.pad_zero = zpad_q && !dot_q && !left_q && (prec_q == '0) && (len != '0);
	end

	urff_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.decimal   (in_item.action == urff_pkg::ACT_DEC),
		.value     (in_item.value),
		.pop       (pop),
		.done      (conv_done),
		.ndig      (conv_ndig),
		.top_digit (top_digit)
	);

	urff_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (emit_start),
		.plan      (plan),
		.top_digit (top_digit),
		.pop       (pop),
		.done      (emit_done),
		.out_item  (out_item)
	);

endmodule

// ===== tb/sv/unsigned_radix_field_formatter_test.sv =====
// Self-checking test of unsigned_radix_field_formatter: formats numbers and checks every
// character against a field predictor kept in this file.
// Depends on urff_pkg, urff_in_if, urff_out_if and the formatter RTL.
module unsigned_radix_field_formatter_test;
	timeunit 1ns;
	timeprecision 1ps;

	// One number to format, as offered on the input channel.
	typedef struct {
		logic [1:0]                   action;
		logic [urff_pkg::VALUE_W-1:0] value;
		logic [urff_pkg::FIELD_W-1:0] field_width;
		logic [urff_pkg::FIELD_W-1:0] precision;
		logic                         has_precision;
		logic                         left_justify;
		logic                         zero_pad;
	} fmt_req_t;

	// One character of a formatted field.
	typedef struct packed {
		logic [7:0] ch;
		logic       ch_valid;
		logic       is_last;
	} fmt_char_t;

	// Receiver behavior when it is not in a long hold-off.
	typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

	localparam logic [1:0] ACT_SPARE  = 2'd3;   // unused code, formats as uppercase hex
	localparam int         IDLE_LIMIT = 3000;   // cycles without any item moving
	localparam int         DRAIN_WAIT = 80;     // settle time after the last character

	logic clk;
	logic arst_n;

	urff_in_if  in_item ();
	urff_out_if out_item ();

	unsigned_radix_field_formatter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.out_item (out_item)
	);

	fmt_char_t pending_chars[$];   // characters still owed by the block, oldest first
	int        mismatches;
	int        burst_left;
	int        gap_max;            // 0 keeps the input valid back to back
	int        burst_max;
	rx_mode_t  rx_mode;
	int        rx_hold;            // long receiver hold-off, counted down by the receiver
	int        rx_phase;
	int        idle_cycles;

	// Clock: 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Build the field for one request and queue its characters.
	function automatic void predict_field(input fmt_req_t r);
		logic [7:0]   rev[$];
		logic [7:0]   digits[$];
		logic [7:0]   field[$];
		string        tab;
		int unsigned  width;
		int unsigned  prec;
		int unsigned  radix;
		int unsigned  pad;
		logic [31:0]  rest;
		logic [7:0]   pad_char;
		width = (r.field_width > urff_pkg::MAX_FIELD) ? urff_pkg::MAX_FIELD : r.field_width;
		prec  = (r.precision > urff_pkg::MAX_FIELD) ? urff_pkg::MAX_FIELD : r.precision;
		radix = (r.action == urff_pkg::ACT_DEC) ? 10 : 16;
		tab   = (r.action == urff_pkg::ACT_LOWER) ? "0123456789abcdef" : "0123456789ABCDEF";

		// Raw digits, least significant first; a dot with precision 0 suppresses a zero.
		if (!(r.has_precision && prec == 0 && r.value == 0)) begin
			if (r.value == 0) begin
				rev.push_back(urff_pkg::CHAR_ZERO);
			end else begin
				rest = r.value;
				while (rest != 0) begin
					rev.push_back(tab[rest % radix]);
					rest = rest / radix;
				end
			end
		end

		// Leading zeros up to the precision, flag or no flag.
		if (rev.size() > 0)
			while (digits.size() + rev.size() < prec)
				digits.push_back(urff_pkg::CHAR_ZERO);
		for (int i = rev.size() - 1; i >= 0; i--)
			digits.push_back(rev[i]);

		// Pad to the field width; zeros only in the plain right-justified case.
		if (width > digits.size()) begin
			pad = width - digits.size();
			pad_char = (r.zero_pad && !r.has_precision && !r.left_justify && prec == 0 &&
				digits.size() != 0) ? urff_pkg::CHAR_ZERO : urff_pkg::CHAR_SPACE;
			if (r.left_justify) begin
				field = digits;
				repeat (pad) field.push_back(urff_pkg::CHAR_SPACE);
			end else begin
				repeat (pad) field.push_back(pad_char);
				foreach (digits[i]) field.push_back(digits[i]);
			end
		end else begin
			field = digits;
		end

		// An empty field still yields one marker item with no character.
		if (field.size() == 0)
			pending_chars.push_back('{ch: urff_pkg::CHAR_NONE, ch_valid: 1'b0, is_last: 1'b1});
		else
			foreach (field[i])
				pending_chars.push_back('{ch: field[i], ch_valid: 1'b1,
					is_last: (i == field.size() - 1)});
	endfunction

	function automatic fmt_req_t make_req(input logic [1:0] action, input logic [31:0] value,
			input int width, input int prec, input bit dot, input bit left, input bit zero);
		fmt_req_t r;
		r.action        = action;
		r.value         = value;
		r.field_width   = width[urff_pkg::FIELD_W-1:0];
		r.precision     = prec[urff_pkg::FIELD_W-1:0];
		r.has_precision = dot;
		r.left_justify  = left;
		r.zero_pad      = zero;
		return r;
	endfunction

	// Offer one item and hold it until the block takes it. Leave valid high on return,
	// so back-to-back items never drop valid within a step.
	task automatic send_item(input fmt_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
			if (gap > 0) begin
				in_item.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(burst_max, 1);
		end
		burst_left--;
		in_item.valid         <= 1'b1;
		in_item.action        <= r.action;
		in_item.value         <= r.value;
		in_item.field_width   <= r.field_width;
		in_item.precision     <= r.precision;
		in_item.has_precision <= r.has_precision;
		in_item.left_justify  <= r.left_justify;
		in_item.zero_pad      <= r.zero_pad;
		do @(posedge clk); while (!in_item.ready);
		predict_field(r);
	endtask

	// Drop valid and wait until the block has delivered everything owed.
	task automatic drain_fields();
		in_item.valid <= 1'b0;
		burst_left = 0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	// Mostly small sizes, some up to the limit, a few past it so the clamp is hit.
	function automatic int rand_size();
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 60)
			return $urandom_range(12, 0);
		else if (pick < 85)
			return $urandom_range(urff_pkg::MAX_FIELD, 13);
		return $urandom_range(127, urff_pkg::MAX_FIELD + 1);
	endfunction

	// Values near digit-count boundaries in both radixes, plus small and full-range ones.
	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		case ($urandom_range(4, 0))
			0: v = $urandom_range(20, 0);
			1: v = $urandom;
			2: v = (32'd1 << $urandom_range(31, 0)) - $urandom_range(1, 0);
			3: v = 32'hFFFF_FFFF - $urandom_range(16, 0);
			default: begin
				v = 32'd1;
				repeat ($urandom_range(9, 1)) v = v * 10;
				v = v - $urandom_range(1, 0);
			end
		endcase
		return v;
	endfunction

	function automatic fmt_req_t rand_req();
		fmt_req_t r;
		r.action        = ($urandom_range(9, 0) == 0) ? ACT_SPARE : 2'($urandom_range(2, 0));
		r.value         = rand_value();
		r.field_width   = urff_pkg::FIELD_W'(rand_size());
		r.precision     = ($urandom_range(2, 0) == 0) ? urff_pkg::FIELD_W'(rand_size()) : '0;
		r.has_precision = 1'($urandom_range(1, 0));
		r.left_justify  = 1'($urandom_range(1, 0));
		r.zero_pad      = 1'($urandom_range(1, 0));
		return r;
	endfunction

	// Extremes of every field, every conversion kind and each corner of the padding rules.
	task automatic test_directed();
		gap_max   = 0;
		burst_max = 4;
		rx_mode   = RX_OPEN;
		send_item(make_req(urff_pkg::ACT_DEC,   32'd0,          0,   0,   0, 0, 0));
		// zero with a dot and precision 0: empty field
		send_item(make_req(urff_pkg::ACT_DEC,   32'd0,          0,   0,   1, 0, 0));
		send_item(make_req(urff_pkg::ACT_LOWER, 32'd0,          5,   0,   1, 0, 1));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd0,          0,   0,   1, 1, 1));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd0,          4,   0,   0, 0, 1));
		send_item(make_req(urff_pkg::ACT_DEC,   32'hFFFF_FFFF,  0,   0,   0, 0, 0));
		send_item(make_req(urff_pkg::ACT_LOWER, 32'hFFFF_FFFF,  0,   0,   0, 0, 0));
		send_item(make_req(urff_pkg::ACT_UPPER, 32'hFFFF_FFFF,  0,   0,   0, 0, 0));
		// unused kind formats as uppercase hex
		send_item(make_req(ACT_SPARE,           32'hABCD_EF01,  0,   0,   0, 0, 0));
		send_item(make_req(urff_pkg::ACT_LOWER, 32'hABCD_EF01,  12,  0,   0, 1, 0));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd12345,      10,  0,   0, 0, 1));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd12345,      10,  3,   1, 0, 1));
		// precision applied without the dot, which also blocks zero padding
		send_item(make_req(urff_pkg::ACT_DEC,   32'd42,         12,  8,   0, 0, 1));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd7,          127, 0,   0, 0, 0));
		send_item(make_req(urff_pkg::ACT_UPPER, 32'h0000_BEEF,  127, 127, 1, 0, 0));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd1000000000, 3,   0,   0, 0, 0));
		send_item(make_req(urff_pkg::ACT_LOWER, 32'h10,         64,  0,   0, 1, 1));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd5,          0,   64,  1, 0, 0));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd0,          3,   1,   1, 0, 0));
		send_item(make_req(urff_pkg::ACT_UPPER, 32'd0,          1,   0,   0, 0, 1));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd9,          1,   0,   0, 1, 0));
		send_item(make_req(urff_pkg::ACT_LOWER, 32'hF0,         0,   2,   1, 0, 0));
		send_item(make_req(urff_pkg::ACT_UPPER, 32'h7FFF_FFFF,  64,  0,   0, 0, 1));
		send_item(make_req(urff_pkg::ACT_DEC,   32'd1,          65,  0,   0, 0, 1));
	endtask

	// Random items in chunks; each chunk picks its own sender and receiver behavior,
	// and the first runs with no idling at all.
	task automatic test_random();
		for (int chunk = 0; chunk < 6; chunk++) begin
			if (chunk == 0) begin
				gap_max = 0;
				rx_mode = RX_OPEN;
			end else begin
				gap_max = $urandom_range(30, 1);
				rx_mode = rx_mode_t'($urandom_range(2, 0));
			end
			burst_max = $urandom_range(6, 1);
			repeat (22) send_item(rand_req());
		end
	endtask

	// Hold the receiver off for a long stretch while items keep coming, so the block
	// fills up and stops taking input.
	task automatic test_backpressure();
		gap_max   = 0;
		burst_max = 8;
		rx_mode   = RX_RANDOM;
		rx_hold   = 250;
		repeat (8) send_item(rand_req());
		while (rx_hold != 0) @(posedge clk);
	endtask

	// Pause the sender until every character has come, then carry on.
	task automatic test_drain_pause();
		gap_max   = 5;
		burst_max = 3;
		rx_mode   = RX_PATTERN;
		repeat (5) send_item(rand_req());
		drain_fields();
		repeat (5) send_item(rand_req());
	endtask

	// Receiver: check each accepted character, then pick ready for the next cycle.
	always @(posedge clk) begin
		fmt_char_t exp_char;
		if (!arst_n) begin
			out_item.ready <= 1'b0;
		end else begin
			if (out_item.valid && out_item.ready) begin
				if (pending_chars.size() == 0) begin
					$display("%0t: unexpected item code=%h valid=%b last=%b", $time,
						out_item.char_code, out_item.char_valid, out_item.last_char);
					mismatches++;
				end else begin
					exp_char = pending_chars.pop_front();
					if (out_item.char_code !== exp_char.ch) begin
						$display("%0t: char_code expected %h, got %h", $time,
							exp_char.ch, out_item.char_code);
						mismatches++;
					end
					if (out_item.char_valid !== exp_char.ch_valid) begin
						$display("%0t: char_valid expected %b, got %b", $time,
							exp_char.ch_valid, out_item.char_valid);
						mismatches++;
					end
					if (out_item.last_char !== exp_char.is_last) begin
						$display("%0t: last_char expected %b, got %b", $time,
							exp_char.is_last, out_item.last_char);
						mismatches++;
					end
				end
			end
			rx_phase++;
			if (rx_hold > 0) begin
				rx_hold--;
				out_item.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:    out_item.ready <= 1'b1;
					RX_RANDOM:  out_item.ready <= ($urandom_range(2, 0) != 0);
					RX_PATTERN: out_item.ready <= !(rx_phase % 7 inside {2, 3, 5});
					default:    out_item.ready <= 1'b1;
				endcase
			end
		end
	end

	// Watchdog: end the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** unsigned_radix_field_formatter: FAILED **");
			$finish;
		end
	end

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		in_item.valid         = 1'b0;
		in_item.action        = urff_pkg::ACT_DEC;
		in_item.value         = '0;
		in_item.field_width   = '0;
		in_item.precision     = '0;
		in_item.has_precision = 1'b0;
		in_item.left_justify  = 1'b0;
		in_item.zero_pad      = 1'b0;
		out_item.ready        = 1'b0;
		mismatches            = 0;
		burst_left            = 0;
		gap_max               = 0;
		burst_max             = 1;
		rx_mode               = RX_OPEN;
		rx_hold               = 0;
		rx_phase              = 0;
		idle_cycles           = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();
		test_backpressure();
		test_drain_pause();

		// Wait out the last fields, then give any stray items time to show up.
		drain_fields();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("** unsigned_radix_field_formatter: PASSED **");
		else
			$display("** unsigned_radix_field_formatter: FAILED **");
		$finish;
	end

endmodule
